@@ src/ssr_pkg.sv @@
package ssr_pkg;

    localparam int STEP_W   = 32;
    localparam int STRIDE_W = 31;
    localparam int REM_W    = STRIDE_W + 1;

    typedef struct packed {
        logic valid;
        logic err;
    } t_ctl;

endpackage

@@ src/ssr_front.sv @@
module ssr_front
    import ssr_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [INDEX_BITS:0]     i_start_value,
    input  logic                    i_start_given,
    input  logic [INDEX_BITS:0]     i_stop_value,
    input  logic                    i_stop_given,
    input  logic [STEP_W-1:0]       i_step_value,
    input  logic                    i_step_given,
    input  logic [INDEX_BITS-1:0]   i_array_length,
    output t_ctl                    o_ctl,
    output logic [INDEX_BITS-1:0]   o_first,
    output logic [INDEX_BITS-1:0]   o_diff,
    output logic [STRIDE_W-1:0]     o_stride
);

    function automatic logic [INDEX_BITS-1:0] wrap_clamp(
        input logic [INDEX_BITS:0]   v,
        input logic [INDEX_BITS-1:0] len
    );
        logic [INDEX_BITS+1:0] sum;
        logic [INDEX_BITS-1:0] res;
        begin
            sum = {v[INDEX_BITS], v} + {2'b00, len};
            if (v[INDEX_BITS]) begin
                res = sum[INDEX_BITS+1] ? '0 : sum[INDEX_BITS-1:0];
            end else begin
                res = (v[INDEX_BITS-1:0] > len) ? len : v[INDEX_BITS-1:0];
            end
            return res;
        end
    endfunction

    logic [STEP_W-1:0]     step;
    logic                  err;
    logic [INDEX_BITS-1:0] first;
    logic [INDEX_BITS-1:0] last;
    logic [INDEX_BITS-1:0] diff;

    t_ctl                  r_ctl;
    t_ctl                  n_ctl;
    logic [INDEX_BITS-1:0] r_first;
    logic [INDEX_BITS-1:0] r_diff;
    logic [STRIDE_W-1:0]   r_stride;

    always_comb begin
        step  = i_step_given ? i_step_value : STEP_W'(1);
        err   = step[STEP_W-1] | (step == '0);
        first = i_start_given ? wrap_clamp(i_start_value, i_array_length) : '0;
        last  = i_stop_given ? wrap_clamp(i_stop_value, i_array_length) : i_array_length;
        diff  = (!err && last > first) ? last - first : '0;
        n_ctl.valid = i_valid;
        n_ctl.err   = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first  <= err ? '0 : first;
            r_diff   <= diff;
            r_stride <= err ? '0 : step[STRIDE_W-1:0];
        end
    end

    assign o_ctl    = r_ctl;
    assign o_first  = r_first;
    assign o_diff   = r_diff;
    assign o_stride = r_stride;

endmodule

@@ src/ssr_div_cell.sv @@
module ssr_div_cell
    import ssr_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_ctl                    i_ctl,
    input  logic [INDEX_BITS-1:0]   i_first,
    input  logic [STRIDE_W-1:0]     i_stride,
    input  logic [REM_W-1:0]        i_rem,
    input  logic [INDEX_BITS-1:0]   i_dq,
    output t_ctl                    o_ctl,
    output logic [INDEX_BITS-1:0]   o_first,
    output logic [STRIDE_W-1:0]     o_stride,
    output logic [REM_W-1:0]        o_rem,
    output logic [INDEX_BITS-1:0]   o_dq
);

    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      divisor;
    logic                  ge;

    t_ctl                  r_ctl;
    logic [INDEX_BITS-1:0] r_first;
    logic [STRIDE_W-1:0]   r_stride;
    logic [REM_W-1:0]      r_rem;
    logic [INDEX_BITS-1:0] r_dq;
    logic [REM_W-1:0]      n_rem;
    logic [INDEX_BITS-1:0] n_dq;

    always_comb begin
        rem_sh  = {i_rem[REM_W-2:0], i_dq[INDEX_BITS-1]};
        divisor = {1'b0, i_stride};
        ge      = (rem_sh >= divisor);
        n_rem   = ge ? rem_sh - divisor : rem_sh;
        n_dq    = {i_dq[INDEX_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first  <= i_first;
            r_stride <= i_stride;
            r_rem    <= n_rem;
            r_dq     <= n_dq;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_first  = r_first;
    assign o_stride = r_stride;
    assign o_rem    = r_rem;
    assign o_dq     = r_dq;

endmodule

@@ src/slice_stride_resolver_core.sv @@
// Pipeline: front register, one register per division cell, then the output register.
// One request per cycle unless stalled; one restoring-division cell per quotient bit.
// The whole chain advances whenever the output register is empty or being taken.
// Reset (synchronous, active low) clears all valid flags; no clearing pass is needed.
module slice_stride_resolver_core
    import ssr_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // start_value, stop_value, step_value, array_length, zero padding
    input  logic [((3*INDEX_BITS+34+7)/8)*8-1:0] s_tdata,
    // start_given, stop_given, step_given
    input  logic [2:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // first_index, stride_out, element_count, zero padding
    output logic [((2*INDEX_BITS+31+7)/8)*8-1:0] m_tdata,
    // status
    output logic [0:0]              m_tuser
);

    localparam int OUT_DATA_W = ((2*INDEX_BITS+31+7)/8)*8;
    localparam int STOP_LO    = INDEX_BITS + 1;
    localparam int STEP_LO    = 2*INDEX_BITS + 2;
    localparam int LEN_LO     = STEP_LO + STEP_W;

    logic                  en;
    t_ctl                  ch_ctl    [0:INDEX_BITS];
    logic [INDEX_BITS-1:0] ch_first  [0:INDEX_BITS];
    logic [STRIDE_W-1:0]   ch_stride [0:INDEX_BITS];
    logic [REM_W-1:0]      ch_rem    [0:INDEX_BITS];
    logic [INDEX_BITS-1:0] ch_dq     [0:INDEX_BITS];

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_status;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [INDEX_BITS-1:0] count;
    t_ctl                  last_ctl;

    assign en       = ~r_out_valid | m_tready;
    assign s_tready = en;

    ssr_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (s_tvalid),
        .i_start_value  (s_tdata[INDEX_BITS:0]),
        .i_start_given  (s_tuser[0]),
        .i_stop_value   (s_tdata[STOP_LO+INDEX_BITS:STOP_LO]),
        .i_stop_given   (s_tuser[1]),
        .i_step_value   (s_tdata[STEP_LO+STEP_W-1:STEP_LO]),
        .i_step_given   (s_tuser[2]),
        .i_array_length (s_tdata[LEN_LO+INDEX_BITS-1:LEN_LO]),
        .o_ctl          (ch_ctl[0]),
        .o_first        (ch_first[0]),
        .o_diff         (ch_dq[0]),
        .o_stride       (ch_stride[0])
    );

    assign ch_rem[0] = '0;

    for (genvar g = 0; g < INDEX_BITS; g++) begin : g_cell
        ssr_div_cell #(
            .INDEX_BITS(INDEX_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctl    (ch_ctl[g]),
            .i_first  (ch_first[g]),
            .i_stride (ch_stride[g]),
            .i_rem    (ch_rem[g]),
            .i_dq     (ch_dq[g]),
            .o_ctl    (ch_ctl[g+1]),
            .o_first  (ch_first[g+1]),
            .o_stride (ch_stride[g+1]),
            .o_rem    (ch_rem[g+1]),
            .o_dq     (ch_dq[g+1])
        );
    end

    assign last_ctl = ch_ctl[INDEX_BITS];

    always_comb begin
        count = ch_dq[INDEX_BITS] + INDEX_BITS'(ch_rem[INDEX_BITS] != '0);
        n_out_data = '0;
        if (!last_ctl.err) begin
            n_out_data[INDEX_BITS-1:0]                         = ch_first[INDEX_BITS];
            n_out_data[INDEX_BITS+STRIDE_W-1:INDEX_BITS]       = ch_stride[INDEX_BITS];
            n_out_data[2*INDEX_BITS+STRIDE_W-1:INDEX_BITS+STRIDE_W] = count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data   <= n_out_data;
            r_out_status <= last_ctl.err;
        end
    end

    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_data;
    assign m_tuser[0] = r_out_status;

endmodule

@@ tb/tb_slice_stride_resolver_core.sv @@
module tb_slice_stride_resolver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    localparam int IDX_W        = 32;
    localparam int IN_W         = ((3*IDX_W+34+7)/8)*8;
    localparam int OUT_W        = ((2*IDX_W+31+7)/8)*8;
    localparam int RANDOM_ITEMS = 1330;
    localparam int LATENCY      = IDX_W + 2;
    localparam int IDLE_LIMIT   = 5000;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_BAD_STEP = 1'b1;

    localparam longint IDX_MAX  = 64'sd4294967295;
    localparam longint IDX_MIN  = -64'sd4294967296;
    localparam longint STEP_MAX = 64'sd2147483647;
    localparam longint STEP_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [IDX_W:0]      start_v;
        logic                start_g;
        logic [IDX_W:0]      stop_v;
        logic                stop_g;
        logic [STEP_W-1:0]   step_v;
        logic                step_g;
        logic [IDX_W-1:0]    len;
    } t_slice_req;

    typedef struct packed {
        logic [IDX_W-1:0]    first;
        logic [STRIDE_W-1:0] stride;
        logic [IDX_W-1:0]    count;
        logic                status;
    } t_slice_res;

    typedef struct {
        t_slice_req req;
        bit         known;
        t_slice_res res;
    } t_slice_row;

    logic              i_clk;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // start_value, stop_value, step_value, array_length, zero padding
    logic [IN_W-1:0]   s_tdata  = '0;
    // start_given, stop_given, step_given
    logic [2:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // first_index, stride_out, element_count, zero padding
    logic [OUT_W-1:0]  m_tdata;
    // status
    logic [0:0]        m_tuser;

    t_slice_res pending_results[$];
    t_slice_row directed_rows[$];
    t_slice_res got_res;
    t_slice_res exp_res;
    int         mismatches     = 0;
    int         requests_sent  = 0;
    int         results_seen   = 0;
    int         rejected_steps = 0;
    int         empty_arrays   = 0;
    bit         sender_calm    = 1'b0;

    slice_stride_resolver_core #(
        .INDEX_BITS(IDX_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint urange(longint lo, longint hi);
        logic [31:0] span;
        span = 32'(hi - lo);
        return lo + longint'({32'd0, $urandom_range(span, 0)});
    endfunction

    function automatic longint clamp_index(longint v, longint len);
        if (v < 0) begin
            v = v + len;
            if (v < 0) return 0;
        end
        if (v > len) return len;
        return v;
    endfunction

    function automatic t_slice_res resolve_slice(t_slice_req r);
        t_slice_res res;
        longint     len;
        longint     step;
        longint     first;
        longint     last;
        longint     count;
        len  = longint'({32'd0, r.len});
        step = 1;
        if (r.step_g) step = longint'($signed(r.step_v));
        if (step <= 0) begin
            res = '{first: '0, stride: '0, count: '0, status: ST_BAD_STEP};
            return res;
        end
        first = 0;
        count = 0;
        if (len != 0) begin
            last = len;
            if (r.start_g) first = clamp_index(longint'($signed(r.start_v)), len);
            if (r.stop_g) last = clamp_index(longint'($signed(r.stop_v)), len);
            if (last > first) count = (last - first + step - 1) / step;
        end
        res.first  = first[IDX_W-1:0];
        res.stride = step[STRIDE_W-1:0];
        res.count  = count[IDX_W-1:0];
        res.status = ST_OK;
        return res;
    endfunction

    function automatic t_slice_req mk_req(bit sg, longint sv, bit pg, longint pv,
                                          bit tg, longint tv, longint len);
        t_slice_req r;
        r.start_v = sv[IDX_W:0];
        r.start_g = sg;
        r.stop_v  = pv[IDX_W:0];
        r.stop_g  = pg;
        r.step_v  = tv[STEP_W-1:0];
        r.step_g  = tg;
        r.len     = len[IDX_W-1:0];
        return r;
    endfunction

    function automatic t_slice_res mk_res(longint first, longint stride, longint count,
                                          logic status);
        t_slice_res res;
        res.first  = first[IDX_W-1:0];
        res.stride = stride[STRIDE_W-1:0];
        res.count  = count[IDX_W-1:0];
        res.status = status;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 8);
    endfunction

    function automatic longint rand_index(longint len);
        longint v;
        longint lim;
        lim = (len == 0) ? 1 : len;
        case ($urandom_range(7, 0))
            0: begin
                v = longint'({32'd0, $urandom});
                if ($urandom_range(1, 0) == 1) v = v + IDX_MIN;
            end
            1: v = 0;
            2: v = len;
            3: v = urange(0, len);
            4: v = -urange(1, lim);
            5: begin
                v = -len - urange(1, 1000);
                if (v < IDX_MIN) v = IDX_MIN;
            end
            6: begin
                v = len + urange(1, 1000);
                if (v > IDX_MAX) v = IDX_MAX;
            end
            default: v = ($urandom_range(1, 0) == 1) ? IDX_MAX : IDX_MIN;
        endcase
        return v;
    endfunction

    function automatic t_slice_req rand_req();
        longint len;
        longint step;
        longint lim;
        int     pick;
        pick = $urandom_range(9, 0);
        if (pick == 0) len = 0;
        else if (pick == 1) len = IDX_MAX;
        else if (pick < 5) len = urange(1, 64);
        else if (pick < 7) len = urange(1, 65535);
        else len = longint'({32'd0, $urandom});
        lim = (len == 0) ? 1 : ((len > STEP_MAX) ? STEP_MAX : len);
        case ($urandom_range(19, 0))
            0:       step = 0;
            1:       step = -1;
            2:       step = -urange(1, -STEP_MIN);
            3:       step = STEP_MAX;
            13, 14, 15, 16: step = urange(1, lim);
            17, 18, 19:     step = urange(1, STEP_MAX);
            default: step = urange(1, 8);
        endcase
        if ($urandom_range(19, 0) < 3) begin
            return mk_req($urandom_range(9, 0) < 7, rand_index(len),
                          $urandom_range(9, 0) < 7, rand_index(len),
                          1'b0, longint'({32'd0, $urandom}), len);
        end
        return mk_req($urandom_range(9, 0) < 7, rand_index(len),
                      $urandom_range(9, 0) < 7, rand_index(len),
                      1'b1, step, len);
    endfunction

    task automatic offer_request(t_slice_req r, t_slice_res res);
        int gap;
        s_tdata  <= IN_W'({r.len, r.step_v, r.stop_v, r.start_v});
        s_tuser  <= {r.step_g, r.stop_g, r.start_g};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        // The transfer took place at this edge.
        pending_results.push_back(res);
        requests_sent++;
        if (res.status == ST_BAD_STEP) rejected_steps++;
        else if (r.len == '0) empty_arrays++;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int gap;
        int run;
        repeat (2) @(posedge i_clk);
        forever begin
            run = $urandom_range(20, 1);
            gap = ($urandom_range(4, 0) == 0) ? 0 : pick_gap();
            m_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            got_res.first  = m_tdata[IDX_W-1:0];
            got_res.stride = m_tdata[IDX_W+STRIDE_W-1:IDX_W];
            got_res.count  = m_tdata[2*IDX_W+STRIDE_W-1:IDX_W+STRIDE_W];
            got_res.status = m_tuser[0];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with nothing expected, actual %h",
                         $time, got_res);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res.first !== exp_res.first) begin
                    mismatches++;
                    $display("%0t: first_index expected %h actual %h",
                             $time, exp_res.first, got_res.first);
                end
                if (got_res.stride !== exp_res.stride) begin
                    mismatches++;
                    $display("%0t: stride_out expected %h actual %h",
                             $time, exp_res.stride, got_res.stride);
                end
                if (got_res.count !== exp_res.count) begin
                    mismatches++;
                    $display("%0t: element_count expected %h actual %h",
                             $time, exp_res.count, got_res.count);
                end
                if (got_res.status !== exp_res.status) begin
                    mismatches++;
                    $display("%0t: status expected %h actual %h",
                             $time, exp_res.status, got_res.status);
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int         i;
        t_slice_req r;
        directed_rows.push_back('{mk_req(0, 0, 0, 0, 0, 0, 10), 1,
                                  mk_res(0, 1, 10, ST_OK)});
        directed_rows.push_back('{mk_req(0, 0, 0, 0, 1, 0, 10), 1,
                                  mk_res(0, 0, 0, ST_BAD_STEP)});
        directed_rows.push_back('{mk_req(1, 3, 1, 8, 1, -1, 10), 1,
                                  mk_res(0, 0, 0, ST_BAD_STEP)});
        directed_rows.push_back('{mk_req(1, 3, 1, 8, 1, STEP_MIN, 10), 1,
                                  mk_res(0, 0, 0, ST_BAD_STEP)});
        directed_rows.push_back('{mk_req(0, 0, 0, 0, 1, STEP_MAX, IDX_MAX), 0,
                                  mk_res(0, 0, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, 5, 1, 3, 1, 3, 0), 1,
                                  mk_res(0, 3, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, 5, 1, 3, 1, 0, 0), 1,
                                  mk_res(0, 0, 0, ST_BAD_STEP)});
        directed_rows.push_back('{mk_req(1, IDX_MAX, 0, 0, 0, 0, 100), 1,
                                  mk_res(100, 1, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, IDX_MIN, 0, 0, 0, 0, 100), 1,
                                  mk_res(0, 1, 100, ST_OK)});
        directed_rows.push_back('{mk_req(1, 0, 1, IDX_MAX, 0, 0, 100), 1,
                                  mk_res(0, 1, 100, ST_OK)});
        directed_rows.push_back('{mk_req(0, 0, 1, IDX_MIN, 0, 0, 100), 1,
                                  mk_res(0, 1, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, -3, 0, 0, 0, 0, 10), 0,
                                  mk_res(0, 0, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, 2, 1, -1, 1, 3, 10), 0,
                                  mk_res(0, 0, 0, ST_OK)});
        directed_rows.push_back('{mk_req(0, -5, 0, 2, 0, 0, 8), 1,
                                  mk_res(0, 1, 8, ST_OK)});
        directed_rows.push_back('{mk_req(1, 2, 1, 6, 0, -7, 8), 1,
                                  mk_res(2, 1, 4, ST_OK)});
        directed_rows.push_back('{mk_req(1, -1, 0, 0, 1, 1, IDX_MAX), 0,
                                  mk_res(0, 0, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, 5, 1, 5, 1, 1, 10), 1,
                                  mk_res(5, 1, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, 0, 1, 1, 1, 1, 1), 1,
                                  mk_res(0, 1, 1, ST_OK)});
        directed_rows.push_back('{mk_req(1, -11, 1, -12, 1, 2, 10), 0,
                                  mk_res(0, 0, 0, ST_OK)});
        directed_rows.push_back('{mk_req(1, 0, 1, 9, 1, 3, 10), 0,
                                  mk_res(0, 0, 0, ST_OK)});
        directed_rows.push_back('{mk_req(0, 0, 0, 0, 1, 1, IDX_MAX), 1,
                                  mk_res(0, 1, IDX_MAX, ST_OK)});
        directed_rows.push_back('{mk_req(1, 7, 1, IDX_MAX, 1, STEP_MAX, IDX_MAX), 0,
                                  mk_res(0, 0, 0, ST_OK)});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_request(directed_rows[k].req,
                          directed_rows[k].known ? directed_rows[k].res
                                                 : resolve_slice(directed_rows[k].req));
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) sender_calm = ($urandom_range(3, 0) == 0);
            r = rand_req();
            offer_request(r, resolve_slice(r));
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Sent %0d slice requests (%0d directed), checked %0d results.",
                 requests_sent, directed_rows.size(), results_seen);
        $display("Covered %0d rejected steps and %0d empty arrays.",
                 rejected_steps, empty_arrays);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ slice_stride_resolver_core.f @@
src/ssr_pkg.sv
src/ssr_front.sv
src/ssr_div_cell.sv
src/slice_stride_resolver_core.sv
tb/tb_slice_stride_resolver_core.sv
